>>> hdl/mnep_pkg.sv
// shared types and constants for the midi note event parser
package mnep_pkg;

  localparam int unsigned Capacity   = 1024;
  localparam int unsigned SlotW      = 11;
  localparam int unsigned IndexW     = 10;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned DataW      = 7;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [DataW-1:0] NoteFloorRst = 7'd11;
  localparam logic [DataW-1:0] VelFloorRst  = 7'd5;
  localparam logic [ByteW-1:0] RunStatusRst = 8'h90;

  // status byte high nibbles
  localparam logic [3:0] StNoteOff  = 4'h8;
  localparam logic [3:0] StNoteOn   = 4'h9;
  localparam logic [3:0] StPolyPres = 4'hA;
  localparam logic [3:0] StCtrl     = 4'hB;
  localparam logic [3:0] StProg     = 4'hC;
  localparam logic [3:0] StChanPres = 4'hD;
  localparam logic [3:0] StBend     = 4'hE;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNoteFloor = 1'b0,
    CfgVelFloor  = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PhStatus = 5'b00001,
    PhData1  = 5'b00010,
    PhData2  = 5'b00100,
    PhSkip2  = 5'b01000,
    PhSkip1  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                 valid;
    logic [CfgIdxW-1:0]   index;
    logic [DataW-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic [IndexW-1:0] event_index;
    logic [TimeW-1:0]  event_time;
    logic              note_on;
    logic [DataW-1:0]  note_number;
    logic [DataW-1:0]  velocity;
    logic              now_full;
  } event_t;

endpackage

>>> hdl/mnep_parser.sv
// byte parser: phase state, running status, slot count and config registers
module mnep_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mnep_pkg::cfg_wr_t             cfg_wr_i,
  input  logic                          byte_valid_i,
  input  logic [mnep_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [mnep_pkg::TimeW-1:0]    timestamp_i,
  output logic                          evt_valid_o,
  output mnep_pkg::event_t              evt_o
);
  import mnep_pkg::*;

  logic [DataW-1:0] note_floor_q, vel_floor_q;
  phase_e           phase_q, phase_d;
  phase_e           saved_q, saved_d;
  logic [ByteW-1:0] run_status_q, run_status_d;
  logic [TimeW-1:0] pend_time_q, pend_time_d;
  logic             pend_on_q, pend_on_d;
  logic [DataW-1:0] pend_note_q, pend_note_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             full_q, full_d;

  logic [SlotW-1:0] slot_inc;
  logic             full_now;
  logic [DataW-1:0] data;

  assign data     = rx_byte_i[DataW-1:0];
  assign slot_inc = slot_q + SlotW'(1);
  assign full_now = {1'b0, slot_inc} >= (SlotW+1)'(Capacity);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_floor_q <= NoteFloorRst;
      vel_floor_q  <= VelFloorRst;
    end else if (cfg_wr_i.valid) begin
      unique case (cfg_idx_e'(cfg_wr_i.index))
        CfgNoteFloor: note_floor_q <= cfg_wr_i.data;
        CfgVelFloor:  vel_floor_q  <= cfg_wr_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d      = phase_q;
    saved_d      = saved_q;
    run_status_d = run_status_q;
    pend_time_d  = pend_time_q;
    pend_on_d    = pend_on_q;
    pend_note_d  = pend_note_q;
    slot_d       = slot_q;
    full_d       = full_q;
    evt_valid_o  = 1'b0;

    evt_o.event_index = slot_q[IndexW-1:0];
    evt_o.event_time  = pend_time_q;
    evt_o.note_on     = pend_on_q;
    evt_o.note_number = pend_note_q;
    evt_o.velocity    = data;
    evt_o.now_full    = full_now;
    if (data < vel_floor_q) begin
      evt_o.note_on  = 1'b0;
      evt_o.velocity = '0;
    end

    if (byte_valid_i && !full_q) begin
      if (rx_byte_i[ByteW-1]) begin
        case (rx_byte_i[ByteW-1 -: 4])
          StNoteOff, StNoteOn: begin
            pend_time_d  = timestamp_i;
            run_status_d = rx_byte_i;
            pend_on_d    = rx_byte_i[4];
            pend_note_d  = '0;
            phase_d      = PhData1;
          end
          StPolyPres, StCtrl, StBend: begin
            saved_d = phase_q;
            phase_d = PhSkip2;
          end
          StProg, StChanPres: begin
            saved_d = phase_q;
            phase_d = PhSkip1;
          end
          default: begin
            // system messages: odd low nibble skips one byte, even skips two
            saved_d = phase_q;
            phase_d = rx_byte_i[0] ? PhSkip1 : PhSkip2;
          end
        endcase
      end else begin
        unique case (phase_q)
          PhData1: begin
            pend_note_d = (data > note_floor_q) ? data : '0;
            phase_d     = PhData2;
          end
          PhData2: begin
            evt_valid_o = 1'b1;
            slot_d      = slot_inc;
            full_d      = full_now;
            phase_d     = PhStatus;
          end
          PhSkip2: phase_d = PhSkip1;
          PhSkip1: phase_d = saved_q;
          default: begin
            // running status: new note under the last note status
            pend_time_d = timestamp_i;
            pend_on_d   = run_status_q[4];
            pend_note_d = data;
            phase_d     = PhData2;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStatus;
      saved_q      <= PhStatus;
      run_status_q <= RunStatusRst;
      pend_time_q  <= '0;
      pend_on_q    <= 1'b0;
      pend_note_q  <= '0;
      slot_q       <= '0;
      full_q       <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      saved_q      <= saved_d;
      run_status_q <= run_status_d;
      pend_time_q  <= pend_time_d;
      pend_on_q    <= pend_on_d;
      pend_note_q  <= pend_note_d;
      slot_q       <= slot_d;
      full_q       <= full_d;
    end
  end

endmodule

>>> hdl/mnep_out_buf.sv
// result register with a skid slot that absorbs one more event under a stall
module mnep_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mnep_pkg::event_t  data_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mnep_pkg::event_t  data_o
);
  import mnep_pkg::*;

  logic   out_valid_q, skid_valid_q;
  event_t out_q, skid_q;
  logic   load;

  assign space_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;
  assign load    = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule

>>> hdl/midi_note_event_parser.sv
// midi note event parser top level: request channels, config port, parser and result buffer
//
// Input channel (in_valid_i/in_ready_o) takes one received MIDI byte plus the
// current timestamp per request. Note on/off messages, including running
// status, are parsed; other status bytes skip their data bytes. The byte that
// completes a note yields one event request on the output channel
// (out_valid_o/out_ready_i); all other bytes yield nothing.
// An event is captured in the result register, or in the skid slot under a stall, when its
// velocity byte is taken. Throughput: one byte per cycle while in_ready_o is high; the parser
// step is combinational logic between the state registers and the result register.
// When the receiver stalls, a skid slot behind the result register absorbs one
// more event; in_ready_o drops only while that slot is occupied.
// Config writes (note floor, velocity floor) are always taken (cfg_ready_o is tied high) and
// must be issued while the block is idle.
// Reset clears the parse state, running status (note on, channel 0), the slot
// count and the full flag; the floors return to 11 and 5. Once the slot count
// reaches capacity the full flag stays set and bytes are taken but ignored.
module midi_note_event_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mnep_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mnep_pkg::DataW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mnep_pkg::ByteW-1:0]     rx_byte_i,
  input  logic [mnep_pkg::TimeW-1:0]     timestamp_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mnep_pkg::IndexW-1:0]    event_index_o,
  output logic [mnep_pkg::TimeW-1:0]     event_time_o,
  output logic                           note_on_o,
  output logic [mnep_pkg::DataW-1:0]     note_number_o,
  output logic [mnep_pkg::DataW-1:0]     velocity_o,
  output logic                           now_full_o
);
  import mnep_pkg::*;

  cfg_wr_t cfg_wr;
  logic    space;
  logic    evt_valid;
  event_t  evt, evt_out;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;
  assign in_ready_o   = space;

  mnep_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_wr),
    .byte_valid_i (in_valid_i && space),
    .rx_byte_i    (rx_byte_i),
    .timestamp_i  (timestamp_i),
    .evt_valid_o  (evt_valid),
    .evt_o        (evt)
  );

  mnep_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_valid),
    .data_i  (evt),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (evt_out)
  );

  assign event_index_o = evt_out.event_index;
  assign event_time_o  = evt_out.event_time;
  assign note_on_o     = evt_out.note_on;
  assign note_number_o = evt_out.note_number;
  assign velocity_o    = evt_out.velocity;
  assign now_full_o    = evt_out.now_full;

endmodule
